[rtl/core/pst_pkg.sv]
// Shared codes and types for the pane stack hit test block.
// Command and status codes of the item ports, and the update opcodes
// broadcast to the stack cells. No dependencies.
package pst_pkg;

  // Fixed port widths of the item fields
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int PORT_TAG_W   = 8;
  localparam int PORT_COORD_W = 16;
  localparam int LEVEL_W      = 4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RAISE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOWER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DROP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_HIT   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD  = 3'd7;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Operation broadcast to every cell of the stack
  typedef enum logic [2:0] {
    UPD_NONE   = 3'd0,
    UPD_ROTATE = 3'd1,
    UPD_WRITE  = 3'd2,
    UPD_DROP   = 3'd3,
    UPD_RAISE  = 3'd4,
    UPD_LOWER  = 3'd5
  } upd_op_t;

endpackage

[rtl/core/pst_cell.sv]
// One stack position of the pane stack: tag and rectangle of one pane.
// Loads from its upper or lower neighbour or from the load bus, as the
// broadcast opcode and its own position decide. Depends on pst_pkg.
module pst_cell #(
  parameter int TAG_BITS   = 8,
  parameter int COORD_BITS = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5,
  parameter int CELL_IDX   = 0
) (
  input  logic                         clk,
  input  pst_pkg::upd_op_t             op,
  input  logic [IDX_W-1:0]             k,
  input  logic [CNT_W-1:0]             cnt,
  input  logic [TAG_BITS-1:0]          up_tag,
  input  logic signed [COORD_BITS-1:0] up_row,
  input  logic signed [COORD_BITS-1:0] up_col,
  input  logic signed [COORD_BITS-1:0] up_height,
  input  logic signed [COORD_BITS-1:0] up_width,
  input  logic [TAG_BITS-1:0]          down_tag,
  input  logic signed [COORD_BITS-1:0] down_row,
  input  logic signed [COORD_BITS-1:0] down_col,
  input  logic signed [COORD_BITS-1:0] down_height,
  input  logic signed [COORD_BITS-1:0] down_width,
  input  logic [TAG_BITS-1:0]          ld_tag,
  input  logic signed [COORD_BITS-1:0] ld_row,
  input  logic signed [COORD_BITS-1:0] ld_col,
  input  logic signed [COORD_BITS-1:0] ld_height,
  input  logic signed [COORD_BITS-1:0] ld_width,
  output logic [TAG_BITS-1:0]          tag,
  output logic signed [COORD_BITS-1:0] row,
  output logic signed [COORD_BITS-1:0] col,
  output logic signed [COORD_BITS-1:0] height,
  output logic signed [COORD_BITS-1:0] width
);
  import pst_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX    = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_NEXT   = CNT_W'(CELL_IDX + 1);
  localparam bit               IS_BOTTOM = (CELL_IDX == 0);

  logic at_or_above;
  logic at_or_below;
  logic below_top;
  logic is_top;
  logic take_up;
  logic take_down;
  logic take_ld;

  // Position of this cell against the target slot and the fill level
  assign at_or_above = (MY_IDX >= k);
  assign at_or_below = (MY_IDX <= k);
  assign below_top   = (MY_NEXT < cnt);
  assign is_top      = (MY_NEXT == cnt);

  // Pick the source of this cell's next contents
  always_comb begin
    take_up   = 1'b0;
    take_down = 1'b0;
    take_ld   = 1'b0;
    unique case (op)
      UPD_ROTATE: take_up = 1'b1;
      UPD_WRITE:  take_ld = (MY_IDX == k);
      UPD_DROP:   take_up = at_or_above && below_top;
      UPD_RAISE: begin
        take_up = at_or_above && below_top;
        take_ld = at_or_above && is_top;
      end
      UPD_LOWER: begin
        take_ld   = IS_BOTTOM;
        take_down = !IS_BOTTOM && at_or_below;
      end
      default: begin
        take_up   = 1'b0;
        take_down = 1'b0;
        take_ld   = 1'b0;
      end
    endcase
  end

  // Hold, shift or load the pane record
  always_ff @(posedge clk) begin
    if (take_up) begin
      tag    <= up_tag;
      row    <= up_row;
      col    <= up_col;
      height <= up_height;
      width  <= up_width;
    end else if (take_down) begin
      tag    <= down_tag;
      row    <= down_row;
      col    <= down_col;
      height <= down_height;
      width  <= down_width;
    end else if (take_ld) begin
      tag    <= ld_tag;
      row    <= ld_row;
      col    <= ld_col;
      height <= ld_height;
      width  <= ld_width;
    end
  end

endmodule

[rtl/core/pst_match.sv]
// Compare unit at the head of the cell chain: tag equality and the
// half-open rectangle cover test against a probe cell.
// Depends on nothing but its parameters.
module pst_match #(
  parameter int TAG_BITS   = 8,
  parameter int COORD_BITS = 16
) (
  input  logic [TAG_BITS-1:0]          head_tag,
  input  logic signed [COORD_BITS-1:0] head_row,
  input  logic signed [COORD_BITS-1:0] head_col,
  input  logic signed [COORD_BITS-1:0] head_height,
  input  logic signed [COORD_BITS-1:0] head_width,
  input  logic [TAG_BITS-1:0]          probe_tag,
  input  logic signed [COORD_BITS-1:0] probe_row,
  input  logic signed [COORD_BITS-1:0] probe_col,
  output logic                         tag_eq,
  output logic                         covered
);

  logic signed [COORD_BITS:0] row_lo;
  logic signed [COORD_BITS:0] row_hi;
  logic signed [COORD_BITS:0] col_lo;
  logic signed [COORD_BITS:0] col_hi;
  logic signed [COORD_BITS:0] p_row;
  logic signed [COORD_BITS:0] p_col;

  assign tag_eq = (head_tag == probe_tag);

  // Bounds one bit wider so the far edge never wraps
  assign row_lo = (COORD_BITS + 1)'(head_row);
  assign col_lo = (COORD_BITS + 1)'(head_col);
  assign row_hi = row_lo + (COORD_BITS + 1)'(head_height);
  assign col_hi = col_lo + (COORD_BITS + 1)'(head_width);
  assign p_row  = (COORD_BITS + 1)'(probe_row);
  assign p_col  = (COORD_BITS + 1)'(probe_col);

  assign covered = (p_row >= row_lo) && (p_row < row_hi) &&
                   (p_col >= col_lo) && (p_col < col_hi);

endmodule

[rtl/core/pane_stack_hit_test_top.sv]
// Pane stack hit test: z-ordered stack of rectangles held in a ring of
// cells, searched by rotating the ring past one compare unit.
// Depends on pst_pkg, pst_cell and pst_match.
//
// One item at a time. A set, raise, lower, drop, query or hit passes
// from acceptance through a scan, an apply and an emit state until
// its result sits in the output register: in the scan the ring of
// cells turns once past the compare unit at position 0 (first tag
// match, or last covering pane for a hit), in the apply every cell
// shifts or loads in parallel to apply the change, and in the emit
// the result moves into the output register. A clear or an unused
// command code skips the turn. A new item is taken only once the block
// is back in idle. in_stall is high from acceptance until the result
// has gone into the output register; a result held back by out_stall
// delays that step, and the register is refilled in the cycle the held
// result is taken. Pane storage is not cleared by reset, only the count.
module pane_stack_hit_test_top #(
  parameter int MAX_PANES  = 16,
  parameter int TAG_BITS   = 8,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pst_pkg::CMD_W-1:0]           cmd,
  input  logic [pst_pkg::PORT_TAG_W-1:0]      pane_tag,
  input  logic signed [pst_pkg::PORT_COORD_W-1:0] row,
  input  logic signed [pst_pkg::PORT_COORD_W-1:0] col,
  input  logic signed [pst_pkg::PORT_COORD_W-1:0] height,
  input  logic signed [pst_pkg::PORT_COORD_W-1:0] width,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [pst_pkg::STATUS_W-1:0]        status,
  output logic [pst_pkg::PORT_TAG_W-1:0]      tag_out,
  output logic signed [pst_pkg::PORT_COORD_W-1:0] geom_row,
  output logic signed [pst_pkg::PORT_COORD_W-1:0] geom_col,
  output logic signed [pst_pkg::PORT_COORD_W-1:0] geom_height,
  output logic signed [pst_pkg::PORT_COORD_W-1:0] geom_width,
  output logic [pst_pkg::LEVEL_W-1:0]         level
);
  import pst_pkg::*;

  localparam int IDX_W = (MAX_PANES > 1) ? $clog2(MAX_PANES) : 1;
  localparam int CNT_W = $clog2(MAX_PANES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PANES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PANES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_APPLY = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_live;
  logic             in_take;

  // Captured command
  logic [CMD_W-1:0]             cmd_q;
  logic [TAG_BITS-1:0]          tag_q;
  logic signed [COORD_BITS-1:0] row_q;
  logic signed [COORD_BITS-1:0] col_q;
  logic signed [COORD_BITS-1:0] height_q;
  logic signed [COORD_BITS-1:0] width_q;

  // Search result
  logic                         found;
  logic [IDX_W-1:0]             k;
  logic [TAG_BITS-1:0]          h_tag;
  logic signed [COORD_BITS-1:0] h_row;
  logic signed [COORD_BITS-1:0] h_col;
  logic signed [COORD_BITS-1:0] h_height;
  logic signed [COORD_BITS-1:0] h_width;

  // Cell ring
  logic [TAG_BITS-1:0]          c_tag    [MAX_PANES];
  logic signed [COORD_BITS-1:0] c_row    [MAX_PANES];
  logic signed [COORD_BITS-1:0] c_col    [MAX_PANES];
  logic signed [COORD_BITS-1:0] c_height [MAX_PANES];
  logic signed [COORD_BITS-1:0] c_width  [MAX_PANES];

  upd_op_t                      op;
  logic [IDX_W-1:0]             k_apply;
  logic [TAG_BITS-1:0]          ld_tag;
  logic signed [COORD_BITS-1:0] ld_row;
  logic signed [COORD_BITS-1:0] ld_col;
  logic signed [COORD_BITS-1:0] ld_height;
  logic signed [COORD_BITS-1:0] ld_width;

  logic tag_eq;
  logic covered;

  // Result fields before and after registering
  logic [STATUS_W-1:0]          r_status;
  logic [TAG_BITS-1:0]          r_tag;
  logic signed [COORD_BITS-1:0] r_row;
  logic signed [COORD_BITS-1:0] r_col;
  logic signed [COORD_BITS-1:0] r_height;
  logic signed [COORD_BITS-1:0] r_width;
  logic [IDX_W-1:0]             r_level;

  logic [STATUS_W-1:0]          res_status;
  logic [TAG_BITS-1:0]          res_tag;
  logic signed [COORD_BITS-1:0] res_row;
  logic signed [COORD_BITS-1:0] res_col;
  logic signed [COORD_BITS-1:0] res_height;
  logic signed [COORD_BITS-1:0] res_width;
  logic [IDX_W-1:0]             res_level;

  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign scan_live = (CNT_W'(scan_idx) < cnt);

  // Ring of cells; the top cell wraps to the bottom for rotation
  for (genvar i = 0; i < MAX_PANES; i++) begin : g_cell
    localparam int UP = (i + 1) % MAX_PANES;
    localparam int DN = (i + MAX_PANES - 1) % MAX_PANES;
    pst_cell #(
      .TAG_BITS   (TAG_BITS),
      .COORD_BITS (COORD_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .CELL_IDX   (i)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .k           (k_apply),
      .cnt         (cnt),
      .up_tag      (c_tag[UP]),
      .up_row      (c_row[UP]),
      .up_col      (c_col[UP]),
      .up_height   (c_height[UP]),
      .up_width    (c_width[UP]),
      .down_tag    (c_tag[DN]),
      .down_row    (c_row[DN]),
      .down_col    (c_col[DN]),
      .down_height (c_height[DN]),
      .down_width  (c_width[DN]),
      .ld_tag      (ld_tag),
      .ld_row      (ld_row),
      .ld_col      (ld_col),
      .ld_height   (ld_height),
      .ld_width    (ld_width),
      .tag         (c_tag[i]),
      .row         (c_row[i]),
      .col         (c_col[i]),
      .height      (c_height[i]),
      .width       (c_width[i])
    );
  end

  // Compare the pane passing position 0
  pst_match #(
    .TAG_BITS   (TAG_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_match (
    .head_tag    (c_tag[0]),
    .head_row    (c_row[0]),
    .head_col    (c_col[0]),
    .head_height (c_height[0]),
    .head_width  (c_width[0]),
    .probe_tag   (tag_q),
    .probe_row   (row_q),
    .probe_col   (col_q),
    .tag_eq      (tag_eq),
    .covered     (covered)
  );

  // Decide the cell operation and the result of the item
  always_comb begin
    op       = (state == S_SCAN) ? UPD_ROTATE : UPD_NONE;
    k_apply  = k;
    cnt_next = cnt;
    r_status = ST_OK;
    r_tag    = h_tag;
    r_row    = h_row;
    r_col    = h_col;
    r_height = h_height;
    r_width  = h_width;
    r_level  = k;
    if (state == S_APPLY) begin
      unique case (cmd_q)
        CMD_SET: begin
          r_tag    = tag_q;
          r_row    = row_q;
          r_col    = col_q;
          r_height = height_q;
          r_width  = width_q;
          if (found) begin
            op = UPD_WRITE;
          end else if (cnt == FULL_CNT) begin
            r_status = ST_FULL;
            r_row    = '0;
            r_col    = '0;
            r_height = '0;
            r_width  = '0;
            r_level  = '0;
          end else begin
            op       = UPD_WRITE;
            k_apply  = IDX_W'(cnt);
            r_level  = IDX_W'(cnt);
            cnt_next = cnt + CNT_W'(1);
          end
        end
        CMD_RAISE, CMD_LOWER, CMD_DROP, CMD_QUERY: begin
          if (!found) begin
            r_status = ST_MISS;
            r_tag    = tag_q;
            r_row    = '0;
            r_col    = '0;
            r_height = '0;
            r_width  = '0;
            r_level  = '0;
          end else if (cmd_q == CMD_RAISE) begin
            op      = UPD_RAISE;
            r_level = IDX_W'(cnt - CNT_W'(1));
          end else if (cmd_q == CMD_LOWER) begin
            op      = UPD_LOWER;
            r_level = '0;
          end else if (cmd_q == CMD_DROP) begin
            op       = UPD_DROP;
            cnt_next = cnt - CNT_W'(1);
          end
        end
        CMD_HIT: begin
          if (!found) begin
            r_status = ST_MISS;
            r_tag    = '0;
            r_row    = '0;
            r_col    = '0;
            r_height = '0;
            r_width  = '0;
            r_level  = '0;
          end
        end
        CMD_CLEAR: begin
          cnt_next = '0;
          r_tag    = '0;
          r_row    = '0;
          r_col    = '0;
          r_height = '0;
          r_width  = '0;
          r_level  = '0;
        end
        default: begin
          r_status = ST_MISS;
          r_tag    = '0;
          r_row    = '0;
          r_col    = '0;
          r_height = '0;
          r_width  = '0;
          r_level  = '0;
        end
      endcase
    end
  end

  // Load bus: new geometry for a write, the held pane for a move
  assign ld_tag    = (op == UPD_WRITE) ? tag_q    : h_tag;
  assign ld_row    = (op == UPD_WRITE) ? row_q    : h_row;
  assign ld_col    = (op == UPD_WRITE) ? col_q    : h_col;
  assign ld_height = (op == UPD_WRITE) ? height_q : h_height;
  assign ld_width  = (op == UPD_WRITE) ? width_q  : h_width;

  // Sequence one item: accept, turn the ring, apply, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            case (cmd) inside
              CMD_CLEAR, CMD_RSVD: state <= S_APPLY;
              default:             state <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          cnt   <= cnt_next;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the item, track the scan position and the match
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= cmd;
      tag_q    <= TAG_BITS'(pane_tag);
      row_q    <= COORD_BITS'(row);
      col_q    <= COORD_BITS'(col);
      height_q <= COORD_BITS'(height);
      width_q  <= COORD_BITS'(width);
      found    <= 1'b0;
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (scan_live) begin
        if (cmd_q == CMD_HIT) begin
          // Keep the last cover seen: the topmost pane wins
          if (covered) begin
            found    <= 1'b1;
            k        <= scan_idx;
            h_tag    <= c_tag[0];
            h_row    <= c_row[0];
            h_col    <= c_col[0];
            h_height <= c_height[0];
            h_width  <= c_width[0];
          end
        end else if (!found && tag_eq) begin
          found    <= 1'b1;
          k        <= scan_idx;
          h_tag    <= c_tag[0];
          h_row    <= c_row[0];
          h_col    <= c_col[0];
          h_height <= c_height[0];
          h_width  <= c_width[0];
        end
      end
    end
  end

  // Hold the result until the output register is free
  always_ff @(posedge clk) begin
    if (state == S_APPLY) begin
      res_status <= r_status;
      res_tag    <= r_tag;
      res_row    <= r_row;
      res_col    <= r_col;
      res_height <= r_height;
      res_width  <= r_width;
      res_level  <= r_level;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || !out_stall)) begin
      status      <= res_status;
      tag_out     <= PORT_TAG_W'(res_tag);
      geom_row    <= PORT_COORD_W'(res_row);
      geom_col    <= PORT_COORD_W'(res_col);
      geom_height <= PORT_COORD_W'(res_height);
      geom_width  <= PORT_COORD_W'(res_width);
      level       <= LEVEL_W'(res_level);
    end
  end

endmodule

[rtl/core/pst_checker.sv]
// Port-level checks for the pane stack hit test block, and the bind
// that attaches them to pane_stack_hit_test_top. Depends on pst_pkg.
module pst_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic [pst_pkg::STATUS_W-1:0]            status,
  input logic [pst_pkg::PORT_TAG_W-1:0]          tag_out,
  input logic signed [pst_pkg::PORT_COORD_W-1:0] geom_row,
  input logic signed [pst_pkg::PORT_COORD_W-1:0] geom_col,
  input logic signed [pst_pkg::PORT_COORD_W-1:0] geom_height,
  input logic signed [pst_pkg::PORT_COORD_W-1:0] geom_width,
  input logic [pst_pkg::LEVEL_W-1:0]             level
);
  import pst_pkg::*;

  // An accepted item keeps the input side closed on the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after an item");

  // A held result keeps its status, tag, level, row and column
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(status) && $stable(tag_out) && $stable(level) &&
       $stable(geom_row) && $stable(geom_col)))
    else $error("held result changed");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("undefined status code");

  // A full or missed result carries no geometry
  a_no_geom: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL || status == ST_MISS)) |->
      (geom_row == '0 && geom_col == '0 && geom_height == '0 &&
       geom_width == '0 && level == '0))
    else $error("geometry reported with a full or miss status");

endmodule

bind pane_stack_hit_test_top pst_checker u_pst_checker (.*);
